/* sv/mecodo_pkg.sv */
// Shared types, constants and codes for the mecanum odometry integrator.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package mecodo_pkg;

  localparam int TRIG_TABLE_BITS_DEF = 10;
  localparam int POSE_FRAC_BITS_DEF  = 16;

  localparam int ENC_W  = 32;
  localparam int SUM_W  = 34;
  localparam int POSE_W = 32;
  localparam int HEAD_W = 16;
  localparam int CFG_W  = 32;
  localparam int CFG_IDX_W = 1;

  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LIN_COEF = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_COEF = 1'd1;

  localparam logic [CFG_W-1:0] LIN_COEF_RST = 32'd605977;
  localparam logic [CFG_W-1:0] ROT_COEF_RST = 32'd287127;

  localparam logic [31:0] SIN_C1 = 32'd1686629713;
  localparam logic [31:0] SIN_C3 = 32'd693598668;
  localparam logic [31:0] SIN_C5 = 32'd85569306;
  localparam logic [31:0] SIN_C7 = 32'd5026995;
  localparam logic [31:0] SIN_C9 = 32'd172272;
  localparam logic [16:0] TRIG_ONE = 17'd16384;

  typedef struct packed {
    logic [SUM_W-1:0] lsum;
    logic [SUM_W-1:0] tsum;
    logic [SUM_W-1:0] rsum;
  } step_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_HEAD,
    B_SCL_L,
    B_SCL_T,
    B_X2,
    B_P7,
    B_P5,
    B_P3,
    B_P1,
    B_V,
    B_R1,
    B_R2,
    B_R3,
    B_R4,
    B_OUT
  } back_state_t;

  typedef struct packed {
    logic pop;
    logic wr;
  } back_stat_t;

endpackage

`default_nettype wire

/* sv/mecanum_odometry_integrator_core.sv */
// Top level of the mecanum odometry integrator: front end, queue and back end.
// Depends on mecodo_pkg, mecodo_front, mecodo_queue and mecodo_back.
//
// Each pushed set of four encoder counts yields one pose result (x, y in
// signed fixed point that wraps, heading as a 16-bit binary angle). The back
// end takes one item at a time and uses a state for each product on its single
// shared 34 by 32 bit multiplier: heading, two step scalings, six steps each
// for sine and cosine, four rotation products, plus a state to take the item
// and one to write the result. Two items may wait in the queue and one result
// in the output register, so the input side keeps taking transfers while a
// result is not yet popped, until the queue is full. Coefficients must be
// written by the user only while the block is idle; the block does not enforce it.
`default_nettype none

module mecanum_odometry_integrator_core #(
  parameter int TRIG_TABLE_BITS = mecodo_pkg::TRIG_TABLE_BITS_DEF,
  parameter int POSE_FRAC_BITS  = mecodo_pkg::POSE_FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_push,
  output logic                                  in_full,
  input  wire logic [mecodo_pkg::ENC_W-1:0]     in_enc_a,
  input  wire logic [mecodo_pkg::ENC_W-1:0]     in_enc_b,
  input  wire logic [mecodo_pkg::ENC_W-1:0]     in_enc_c,
  input  wire logic [mecodo_pkg::ENC_W-1:0]     in_enc_d,
  output logic                                  out_empty,
  input  wire logic                             out_pop,
  output logic [mecodo_pkg::POSE_W-1:0]         out_pose_x,
  output logic [mecodo_pkg::POSE_W-1:0]         out_pose_y,
  output logic [mecodo_pkg::HEAD_W-1:0]         out_pose_heading,
  input  wire logic                             cfg_we,
  input  wire logic [mecodo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mecodo_pkg::CFG_W-1:0]     cfg_data
);

  logic                   q_push;
  logic                   q_empty;
  mecodo_pkg::step_t      q_wr_data;
  mecodo_pkg::step_t      q_rd_data;
  mecodo_pkg::back_stat_t stat;

  mecodo_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .q_full   (in_full),
    .in_enc_a (in_enc_a),
    .in_enc_b (in_enc_b),
    .in_enc_c (in_enc_c),
    .in_enc_d (in_enc_d),
    .q_push   (q_push),
    .q_data   (q_wr_data)
  );

  mecodo_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (stat.pop),
    .rd_data (q_rd_data),
    .full    (in_full),
    .empty   (q_empty)
  );

  mecodo_back #(
    .TRIG_TABLE_BITS (TRIG_TABLE_BITS),
    .POSE_FRAC_BITS  (POSE_FRAC_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .q_empty          (q_empty),
    .q_data           (q_rd_data),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_pose_x       (out_pose_x),
    .out_pose_y       (out_pose_y),
    .out_pose_heading (out_pose_heading),
    .stat             (stat)
  );

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !q_empty)
    else $error("queue reports full while empty");

  a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pop |-> !q_empty)
    else $error("back end took an item from an empty queue");

  a_write_shows: assert property (@(posedge clk) disable iff (!rst_n)
    stat.wr |=> !out_empty)
    else $error("result write did not appear on the output");

endmodule

`default_nettype wire

/* sv/mecodo_front.sv */
// Front end: takes encoder samples, keeps the previous counts and forms the
// wheel combinations. Depends on mecodo_pkg.
`default_nettype none

module mecodo_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  input  wire logic                        q_full,
  input  wire logic [mecodo_pkg::ENC_W-1:0] in_enc_a,
  input  wire logic [mecodo_pkg::ENC_W-1:0] in_enc_b,
  input  wire logic [mecodo_pkg::ENC_W-1:0] in_enc_c,
  input  wire logic [mecodo_pkg::ENC_W-1:0] in_enc_d,
  output logic                             q_push,
  output mecodo_pkg::step_t                q_data
);

  logic [mecodo_pkg::ENC_W-1:0] prev_r [4];
  logic [mecodo_pkg::ENC_W-1:0] d [4];
  logic [mecodo_pkg::SUM_W-1:0] e [4];

  assign q_push = in_push && !q_full;

  always_comb begin
    d[0] = in_enc_a - prev_r[0];
    d[1] = in_enc_b - prev_r[1];
    d[2] = in_enc_c - prev_r[2];
    d[3] = in_enc_d - prev_r[3];
    for (int i = 0; i < 4; i++) begin
      e[i] = {{2{d[i][mecodo_pkg::ENC_W-1]}}, d[i]};
    end
    q_data.lsum = e[0] + e[1] + e[2] + e[3];
    q_data.tsum = e[0] - e[1] - e[2] + e[3];
    q_data.rsum = e[0] - e[1] + e[2] - e[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        prev_r[i] <= '0;
      end
    end else if (q_push) begin
      prev_r[0] <= in_enc_a;
      prev_r[1] <= in_enc_b;
      prev_r[2] <= in_enc_c;
      prev_r[3] <= in_enc_d;
    end
  end

endmodule

`default_nettype wire

/* sv/mecodo_queue.sv */
// Short queue of wheel combinations between the front end and the back end.
// Depends on mecodo_pkg.
`default_nettype none

module mecodo_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  mecodo_pkg::step_t wr_data,
  input  wire logic         pop,
  output mecodo_pkg::step_t rd_data,
  output logic              full,
  output logic              empty
);

  localparam int PW = $clog2(mecodo_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(mecodo_pkg::QUEUE_DEPTH + 1);

  mecodo_pkg::step_t mem [mecodo_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full    = (count_r == CW'(mecodo_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (wr_ptr_r == PW'(mecodo_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= (rd_ptr_r == PW'(mecodo_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CW'(push && !full) - CW'(pop && !empty);
    end
  end

endmodule

`default_nettype wire

/* sv/mecodo_back.sv */
// Back end: heading update, step scaling, sine evaluation and rotation on one
// shared multiplier, plus the configuration registers. Depends on mecodo_pkg.
`default_nettype none

module mecodo_back #(
  parameter int TRIG_TABLE_BITS = mecodo_pkg::TRIG_TABLE_BITS_DEF,
  parameter int POSE_FRAC_BITS  = mecodo_pkg::POSE_FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [mecodo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mecodo_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                             q_empty,
  input  mecodo_pkg::step_t                     q_data,
  input  wire logic                             out_pop,
  output logic                                  out_empty,
  output logic [mecodo_pkg::POSE_W-1:0]         out_pose_x,
  output logic [mecodo_pkg::POSE_W-1:0]         out_pose_y,
  output logic [mecodo_pkg::HEAD_W-1:0]         out_pose_heading,
  output mecodo_pkg::back_stat_t                stat
);

  localparam int TB  = TRIG_TABLE_BITS;
  localparam int IW  = TB + 2;
  localparam int SH  = 32 - POSE_FRAC_BITS;
  localparam int PW  = mecodo_pkg::MUL_P_W;
  localparam int AW  = mecodo_pkg::MUL_A_W;
  localparam int BW  = mecodo_pkg::MUL_B_W;
  localparam int SW  = mecodo_pkg::SUM_W;
  localparam int RW  = 48;

  mecodo_pkg::back_state_t state_r, state_nxt;

  logic [mecodo_pkg::CFG_W-1:0] lin_coef_r, rot_coef_r;
  logic [SW-1:0]  lsum_r, tsum_r, rsum_r;
  logic [31:0]    head_r, acc_x_r, acc_y_r;
  logic [31:0]    sl_r, st_r;
  logic [30:0]    x2_r;
  logic [31:0]    p_r;
  logic [15:0]    sin_r, cos_r;
  logic           cos_ph_r;
  logic signed [RW-1:0] acc1_r, acc2_r;
  logic           out_valid_r;
  logic [31:0]    out_x_r, out_y_r;
  logic [15:0]    out_h_r;

  logic [AW-1:0]  mul_a;
  logic [BW-1:0]  mul_b;
  logic [PW-1:0]  prod, prod30, m_sc;
  logic [IW-1:0]  idx;
  logic [TB+1:0]  kk;
  logic [30:0]    x;
  logic           trig_neg;
  logic [SW-1:0]  sc_src, sc_mag;
  logic           sc_neg;
  logic [31:0]    sc_sat, sc_res;
  logic [31:0]    v30;
  logic [16:0]    r_raw, r_cap;
  logic [15:0]    trig_val;
  logic [31:0]    rot_l, rot_r_mag_src;
  logic [15:0]    rot_t;
  logic [31:0]    rot_lmag;
  logic [15:0]    rot_tmag;
  logic           rot_neg;
  logic signed [RW-1:0] term;
  logic signed [RW:0]   w1, w2;
  logic signed [RW:0]   dx_full, dy_full;
  logic           out_free;

  assign out_free = !out_valid_r || out_pop;

  always_comb begin
    idx = head_r[31 -: IW];
    if (cos_ph_r) begin
      idx = idx + IW'(1 << TB);
    end
    trig_neg = idx[TB+1];
    if (idx[TB]) begin
      kk = (TB+2)'(1 << TB) - (TB+2)'(idx[TB-1:0]);
    end else begin
      kk = (TB+2)'(idx[TB-1:0]);
    end
    x = 31'(kk) << (30 - TB);
  end

  always_comb begin
    sc_src   = (state_r == mecodo_pkg::B_SCL_T) ? tsum_r : lsum_r;
    sc_neg   = sc_src[SW-1];
    sc_mag   = sc_neg ? (SW'(0) - sc_src) : sc_src;
    rot_l    = (state_r == mecodo_pkg::B_R2 || state_r == mecodo_pkg::B_R4) ? st_r : sl_r;
    rot_t    = (state_r == mecodo_pkg::B_R1 || state_r == mecodo_pkg::B_R4) ? cos_r : sin_r;
    rot_r_mag_src = rot_l;
    rot_lmag = rot_r_mag_src[31] ? (32'd0 - rot_r_mag_src) : rot_r_mag_src;
    rot_tmag = rot_t[15] ? (16'd0 - rot_t) : rot_t;
    rot_neg  = rot_l[31] ^ rot_t[15];
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      mecodo_pkg::B_HEAD: begin
        mul_a = AW'(rsum_r[31:0]);
        mul_b = rot_coef_r;
      end
      mecodo_pkg::B_SCL_L, mecodo_pkg::B_SCL_T: begin
        mul_a = sc_mag;
        mul_b = lin_coef_r;
      end
      mecodo_pkg::B_X2: begin
        mul_a = AW'(x);
        mul_b = BW'(x);
      end
      mecodo_pkg::B_P7: begin
        mul_a = AW'(x2_r);
        mul_b = mecodo_pkg::SIN_C9;
      end
      mecodo_pkg::B_P5, mecodo_pkg::B_P3, mecodo_pkg::B_P1: begin
        mul_a = AW'(x2_r);
        mul_b = p_r;
      end
      mecodo_pkg::B_V: begin
        mul_a = AW'(x);
        mul_b = p_r;
      end
      mecodo_pkg::B_R1, mecodo_pkg::B_R2, mecodo_pkg::B_R3, mecodo_pkg::B_R4: begin
        mul_a = AW'(rot_lmag);
        mul_b = BW'(rot_tmag);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod   = PW'(mul_a) * PW'(mul_b);
    prod30 = prod >> 30;
    m_sc   = prod >> SH;
    if (!sc_neg && m_sc > PW'(32'h7FFF_FFFF)) begin
      sc_sat = 32'h7FFF_FFFF;
    end else if (sc_neg && m_sc > PW'(32'h8000_0000)) begin
      sc_sat = 32'h8000_0000;
    end else begin
      sc_sat = m_sc[31:0];
    end
    sc_res = sc_neg ? (32'd0 - sc_sat) : sc_sat;
    v30    = prod30[31:0];
    r_raw  = 17'((33'(v30) + 33'd32768) >> 16);
    r_cap  = (r_raw > mecodo_pkg::TRIG_ONE) ? mecodo_pkg::TRIG_ONE : r_raw;
    trig_val = trig_neg ? (16'd0 - r_cap[15:0]) : r_cap[15:0];
    term   = rot_neg ? (RW'(0) - prod[RW-1:0]) : prod[RW-1:0];
    w1     = {acc1_r[RW-1], acc1_r} + (RW+1)'(8192);
    w2     = {acc2_r[RW-1], acc2_r} + (RW+1)'(8192);
    dx_full = w1 >>> 14;
    dy_full = w2 >>> 14;
  end

  always_comb begin
    state_nxt = state_r;
    stat.pop  = 1'b0;
    stat.wr   = 1'b0;
    case (state_r)
      mecodo_pkg::B_IDLE: begin
        if (!q_empty) begin
          stat.pop  = 1'b1;
          state_nxt = mecodo_pkg::B_HEAD;
        end
      end
      mecodo_pkg::B_HEAD:  state_nxt = mecodo_pkg::B_SCL_L;
      mecodo_pkg::B_SCL_L: state_nxt = mecodo_pkg::B_SCL_T;
      mecodo_pkg::B_SCL_T: state_nxt = mecodo_pkg::B_X2;
      mecodo_pkg::B_X2:    state_nxt = mecodo_pkg::B_P7;
      mecodo_pkg::B_P7:    state_nxt = mecodo_pkg::B_P5;
      mecodo_pkg::B_P5:    state_nxt = mecodo_pkg::B_P3;
      mecodo_pkg::B_P3:    state_nxt = mecodo_pkg::B_P1;
      mecodo_pkg::B_P1:    state_nxt = mecodo_pkg::B_V;
      mecodo_pkg::B_V: begin
        state_nxt = cos_ph_r ? mecodo_pkg::B_R1 : mecodo_pkg::B_X2;
      end
      mecodo_pkg::B_R1:    state_nxt = mecodo_pkg::B_R2;
      mecodo_pkg::B_R2:    state_nxt = mecodo_pkg::B_R3;
      mecodo_pkg::B_R3:    state_nxt = mecodo_pkg::B_R4;
      mecodo_pkg::B_R4:    state_nxt = mecodo_pkg::B_OUT;
      mecodo_pkg::B_OUT: begin
        if (out_free) begin
          stat.wr   = 1'b1;
          state_nxt = mecodo_pkg::B_IDLE;
        end
      end
      default: state_nxt = mecodo_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mecodo_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_coef_r <= mecodo_pkg::LIN_COEF_RST;
      rot_coef_r <= mecodo_pkg::ROT_COEF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mecodo_pkg::REG_LIN_COEF: lin_coef_r <= cfg_data;
        mecodo_pkg::REG_ROT_COEF: rot_coef_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      out_valid_r <= 1'b0;
      cos_ph_r    <= 1'b0;
    end else begin
      if (state_r == mecodo_pkg::B_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        mecodo_pkg::B_IDLE: begin
          cos_ph_r <= 1'b0;
          lsum_r   <= q_data.lsum;
          tsum_r   <= q_data.tsum;
          rsum_r   <= q_data.rsum;
        end
        mecodo_pkg::B_HEAD:  head_r <= head_r + prod[31:0];
        mecodo_pkg::B_SCL_L: sl_r   <= sc_res;
        mecodo_pkg::B_SCL_T: st_r   <= sc_res;
        mecodo_pkg::B_X2:    x2_r   <= prod30[30:0];
        mecodo_pkg::B_P7:    p_r    <= mecodo_pkg::SIN_C7 - prod30[31:0];
        mecodo_pkg::B_P5:    p_r    <= mecodo_pkg::SIN_C5 - prod30[31:0];
        mecodo_pkg::B_P3:    p_r    <= mecodo_pkg::SIN_C3 - prod30[31:0];
        mecodo_pkg::B_P1:    p_r    <= mecodo_pkg::SIN_C1 - prod30[31:0];
        mecodo_pkg::B_V: begin
          if (cos_ph_r) begin
            cos_r <= trig_val;
          end else begin
            sin_r <= trig_val;
          end
          cos_ph_r <= 1'b1;
        end
        mecodo_pkg::B_R1: acc1_r <= term;
        mecodo_pkg::B_R2: acc1_r <= acc1_r - term;
        mecodo_pkg::B_R3: acc2_r <= term;
        mecodo_pkg::B_R4: acc2_r <= acc2_r + term;
        mecodo_pkg::B_OUT: begin
          if (out_free) begin
            acc_x_r     <= acc_x_r + dx_full[31:0];
            acc_y_r     <= acc_y_r + dy_full[31:0];
            out_x_r     <= acc_x_r + dx_full[31:0];
            out_y_r     <= acc_y_r + dy_full[31:0];
            out_h_r     <= head_r[31:16];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_empty        = !out_valid_r;
  assign out_pose_x       = out_x_r;
  assign out_pose_y       = out_y_r;
  assign out_pose_heading = out_h_r;

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for mecanum_odometry_integrator_core: a pose predictor
// checks every popped result. Depends on mecodo_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [mecodo_pkg::ENC_W-1:0] a;
    logic [mecodo_pkg::ENC_W-1:0] b;
    logic [mecodo_pkg::ENC_W-1:0] c;
    logic [mecodo_pkg::ENC_W-1:0] d;
  } counts_t;

  typedef struct packed {
    logic [mecodo_pkg::POSE_W-1:0] x;
    logic [mecodo_pkg::POSE_W-1:0] y;
    logic [mecodo_pkg::HEAD_W-1:0] heading;
  } pose_t;

  localparam int TB_TRIG = mecodo_pkg::TRIG_TABLE_BITS_DEF;
  localparam int TB_FRAC = mecodo_pkg::POSE_FRAC_BITS_DEF;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [mecodo_pkg::ENC_W-1:0] in_enc_a = '0, in_enc_b = '0, in_enc_c = '0, in_enc_d = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [mecodo_pkg::POSE_W-1:0] out_pose_x, out_pose_y;
  logic [mecodo_pkg::HEAD_W-1:0] out_pose_heading;
  logic cfg_we = 1'b0;
  logic [mecodo_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mecodo_pkg::CFG_W-1:0] cfg_data = '0;

  counts_t pending_counts[$];
  pose_t expected_poses[$];
  logic [31:0] lin_coef_m, rot_coef_m, acc_x_m, acc_y_m, acc_head_m;
  logic [31:0] prev_m[4];
  int errors = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit calm = 1'b0;
  int transfers_in = 0;
  int transfers_out = 0;

  always #5 clk = ~clk;

  mecanum_odometry_integrator_core dut (.*);

  function automatic longint scale_body(longint v, logic [31:0] coef);
    logic [63:0] mag, phi, plo, t, m;
    bit neg;
    neg = v < 0;
    mag = neg ? -v : v;
    phi = mag * coef[31:16];
    plo = mag * coef[15:0];
    t = phi + (plo >> 16);
    if (32 - TB_FRAC >= 16) m = t >> (32 - TB_FRAC - 16);
    else m = (t << (16 - (32 - TB_FRAC))) | ((plo & 64'hFFFF) >> (32 - TB_FRAC));
    if (!neg && m > 64'h7FFFFFFF) m = 64'h7FFFFFFF;
    if (neg && m > 64'h80000000) m = 64'h80000000;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint quarter_wave(logic [31:0] k);
    logic [63:0] x, x2, p, v, r;
    x = 64'(k) << (30 - TB_TRIG);
    x2 = (x * x) >> 30;
    p = mecodo_pkg::SIN_C7 - ((x2 * mecodo_pkg::SIN_C9) >> 30);
    p = mecodo_pkg::SIN_C5 - ((x2 * p) >> 30);
    p = mecodo_pkg::SIN_C3 - ((x2 * p) >> 30);
    p = mecodo_pkg::SIN_C1 - ((x2 * p) >> 30);
    v = (x * p) >> 30;
    r = (v + 32768) >> 16;
    if (r > mecodo_pkg::TRIG_ONE) r = mecodo_pkg::TRIG_ONE;
    return longint'(r);
  endfunction

  function automatic longint sine_of(logic [31:0] idx);
    logic [31:0] q, k;
    longint val;
    q = (idx >> TB_TRIG) & 3;
    k = idx & ((1 << TB_TRIG) - 1);
    if (q[0]) k = (1 << TB_TRIG) - k;
    val = quarter_wave(k);
    return q[1] ? -val : val;
  endfunction

  function automatic longint round_grid(longint v);
    return (v + 8192) >>> 14;
  endfunction

  function automatic pose_t integrate_pose(counts_t cnt);
    longint dl[4];
    logic [31:0] now[4], diff, idx;
    longint ls, ts, rs, sl, st, s, c;
    pose_t p;
    now = '{cnt.a, cnt.b, cnt.c, cnt.d};
    for (int i = 0; i < 4; i++) begin
      diff = now[i] - prev_m[i];
      dl[i] = longint'(signed'(diff));
      prev_m[i] = now[i];
    end
    ls = dl[0] + dl[1] + dl[2] + dl[3];
    ts = dl[0] - dl[1] - dl[2] + dl[3];
    rs = dl[0] - dl[1] + dl[2] - dl[3];
    acc_head_m = acc_head_m + 32'(rs) * rot_coef_m;
    sl = scale_body(ls, lin_coef_m);
    st = scale_body(ts, lin_coef_m);
    idx = acc_head_m >> (30 - TB_TRIG);
    s = sine_of(idx);
    c = sine_of(idx + (1 << TB_TRIG));
    acc_x_m = acc_x_m + 32'(round_grid(sl * c - st * s));
    acc_y_m = acc_y_m + 32'(round_grid(sl * s + st * c));
    p.x = acc_x_m;
    p.y = acc_y_m;
    p.heading = acc_head_m[31:16];
    return p;
  endfunction

  always @(posedge clk) begin
    if (in_push && !in_full) begin
      expected_poses.push_back(integrate_pose(pending_counts.pop_front()));
      transfers_in++;
    end
    if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_push <= 1'b0;
    end else if ((!in_push || !in_full) && !calm && $urandom_range(9) == 0) begin
      send_gap <= $urandom_range(6, 1) - 1;
      in_push <= 1'b0;
    end else if (!in_push || !in_full) begin
      if (pending_counts.size() > 0) begin
        in_push <= 1'b1;
        {in_enc_a, in_enc_b, in_enc_c, in_enc_d} <= pending_counts[0];
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (out_pop && !out_empty) begin
      transfers_out++;
      if (expected_poses.size() == 0) begin
        $error("result transfer with no pose expected");
        errors++;
      end else begin
        pose_t e;
        e = expected_poses.pop_front();
        if (out_pose_x !== e.x) begin
          $error("pose_x expected %0d got %0d", $signed(e.x), $signed(out_pose_x));
          errors++;
        end
        if (out_pose_y !== e.y) begin
          $error("pose_y expected %0d got %0d", $signed(e.y), $signed(out_pose_y));
          errors++;
        end
        if (out_pose_heading !== e.heading) begin
          $error("pose_heading expected %0d got %0d", e.heading, out_pose_heading);
          errors++;
        end
      end
    end
    if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_pop <= 1'b0;
    end else if (!calm && $urandom_range(7) == 0) begin
      recv_gap <= $urandom_range(6, 1) - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
    if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL mecanum_odometry_integrator_core");
      $finish;
    end
  end

  task automatic write_coef(logic [mecodo_pkg::CFG_IDX_W-1:0] idx,
                            logic [mecodo_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == mecodo_pkg::REG_LIN_COEF) lin_coef_m = val;
    else rot_coef_m = val;
  endtask

  task automatic drain();
    while (pending_counts.size() > 0 || in_push || expected_poses.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    return $urandom();
  endfunction

  task automatic queue_walk(int n, int span);
    counts_t cur;
    cur = {prev_m[0], prev_m[1], prev_m[2], prev_m[3]};
    if (pending_counts.size() > 0) cur = pending_counts[$];
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: cur = {rand_word(), rand_word(), rand_word(), rand_word()};
        1: cur = {cur.a + 32'h80000000, cur.b - 32'h7FFFFFFF, cur.c, cur.d + 32'd1};
        default: begin
          cur.a += $urandom_range(2 * span) - span;
          cur.b += $urandom_range(2 * span) - span;
          cur.c += $urandom_range(2 * span) - span;
          cur.d += $urandom_range(2 * span) - span;
        end
      endcase
      pending_counts.push_back(cur);
    end
  endtask

  initial begin
    lin_coef_m = mecodo_pkg::LIN_COEF_RST;
    rot_coef_m = mecodo_pkg::ROT_COEF_RST;
    acc_x_m = '0; acc_y_m = '0; acc_head_m = '0;
    prev_m = '{default: '0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: extremes, encoder wrap, half-range jumps and pure motions.
    pending_counts.push_back({32'd0, 32'd0, 32'd0, 32'd0});
    pending_counts.push_back({32'd100, 32'd100, 32'd100, 32'd100});
    pending_counts.push_back({32'd200, 32'd0, 32'd200, 32'd0});
    pending_counts.push_back({32'd300, 32'd100, 32'd100, 32'd300});
    pending_counts.push_back({32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF});
    pending_counts.push_back({32'd5, 32'd5, 32'd5, 32'd5});
    pending_counts.push_back({32'h80000005, 32'h80000005, 32'h80000005, 32'h80000005});
    pending_counts.push_back({32'h00000005, 32'h80000005, 32'h00000005, 32'h80000005});
    pending_counts.push_back({32'h7FFFFFFF, 32'h0, 32'hAAAAAAAA, 32'h55555555});
    pending_counts.push_back({32'h0, 32'h7FFFFFFF, 32'h55555555, 32'hAAAAAAAA});
    drain();
    write_coef(mecodo_pkg::REG_LIN_COEF, 32'hFFFFFFFF);
    write_coef(mecodo_pkg::REG_ROT_COEF, 32'hFFFFFFFF);
    pending_counts.push_back({32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000});
    pending_counts.push_back({32'hFFFFFFFF, 32'h0, 32'h0, 32'hFFFFFFFF});
    pending_counts.push_back({32'h0, 32'h0, 32'h0, 32'h0});
    drain();
    write_coef(mecodo_pkg::REG_LIN_COEF, 32'd0);
    write_coef(mecodo_pkg::REG_ROT_COEF, 32'd0);
    pending_counts.push_back({32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hF0F0F0F0});
    drain();
    // Random phases under several coefficient settings.
    for (int ph = 0; ph < 6; ph++) begin
      write_coef(mecodo_pkg::REG_LIN_COEF,
                 ph == 0 ? mecodo_pkg::LIN_COEF_RST : rand_word() >> $urandom_range(31));
      write_coef(mecodo_pkg::REG_ROT_COEF,
                 ph == 0 ? mecodo_pkg::ROT_COEF_RST : rand_word() >> $urandom_range(31));
      queue_walk(150, ph < 3 ? 400 : 100000);
      drain();
    end
    calm = 1'b1;
    queue_walk(50, 1000);
    drain();
    $display("Moved %0d encoder sets in and %0d poses out over three directed and",
             transfers_in, transfers_out);
    $display("six random coefficient phases, with wrap, half-range jumps and stalls.");
    if (errors == 0) $display("PASS mecanum_odometry_integrator_core");
    else $display("FAIL mecanum_odometry_integrator_core");
    $finish;
  end
endmodule
